// ===== sv/cchd_pkg.sv =====
// shared types, constants and helpers for the cbor head decoder
// no dependencies; compiled before the interfaces and modules
package cchd_pkg;

   // additional info codes of the initial byte
   localparam logic [4:0] AI_ONE   = 5'd24;
   localparam logic [4:0] AI_TWO   = 5'd25;
   localparam logic [4:0] AI_FOUR  = 5'd26;
   localparam logic [4:0] AI_EIGHT = 5'd27;

   // argument widths in bytes
   localparam logic [3:0] ARG_W0 = 4'd0;
   localparam logic [3:0] ARG_W1 = 4'd1;
   localparam logic [3:0] ARG_W2 = 4'd2;
   localparam logic [3:0] ARG_W4 = 4'd4;
   localparam logic [3:0] ARG_W8 = 4'd8;

   // status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // decoder state between requests
   typedef struct packed {
      logic [3:0]  bytes_left;
      logic [3:0]  arg_width;
      logic [63:0] accumulator;
      logic        error_latched;
   } head_state_type;

   // one optional result per request
   typedef struct packed {
      logic        valid;
      logic [63:0] argument;
      logic        status;
   } head_result_type;

   localparam head_state_type IDLE_STATE = '{
      bytes_left: ARG_W0, arg_width: ARG_W0, accumulator: 64'd0, error_latched: 1'b0
   };

   // true when the argument could not have used a shorter encoding
   function automatic logic is_minimal(input logic [3:0] width, input logic [63:0] value);
      logic result;
      begin
         case (width)
            ARG_W1:  result = (value[7:0] >= {3'd0, AI_ONE});
            ARG_W2:  result = (value[15:8] != 8'd0);
            ARG_W4:  result = (value[31:16] != 16'd0);
            ARG_W8:  result = (value[63:32] != 32'd0);
            default: result = 1'b1;
         endcase
         return result;
      end
   endfunction

endpackage

// ===== sv/cchd_req_if.sv =====
// request channel: valid/ready handshake with one byte of the encoded buffer
// no dependencies
interface cchd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [2:0] head_major;
   logic       buffer_end;

   modport source (output valid, data_byte, head_major, buffer_end, input ready);
   modport sink   (input valid, data_byte, head_major, buffer_end, output ready);
endinterface

// ===== sv/cchd_rsp_if.sv =====
// result channel: valid/ready handshake with a decoded head argument and status
// no dependencies
interface cchd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] argument;
   logic        status;

   modport source (output valid, argument, status, input ready);
   modport sink   (input valid, argument, status, output ready);
endinterface

// ===== sv/cchd_head_step.sv =====
// next-state and result logic for one byte of the head decoder
// depends on cchd_pkg
module cchd_head_step (
   input  cchd_pkg::head_state_type  cur_state,
   input  logic [7:0]                data_byte,
   input  logic [2:0]                head_major,
   input  logic                      buffer_end,
   output cchd_pkg::head_state_type  nxt_state,
   output cchd_pkg::head_result_type result
);
   import cchd_pkg::*;

   logic [2:0]  major;
   logic [4:0]  add_info;
   logic [3:0]  width;
   logic        reserved;
   logic [63:0] acc_shift;
   logic [3:0]  left_m1;

   assign major     = data_byte[7:5];
   assign add_info  = data_byte[4:0];
   assign acc_shift = {cur_state.accumulator[55:0], data_byte};
   assign left_m1   = cur_state.bytes_left - 4'd1;

   // argument width announced by the initial byte
   always_comb begin
      reserved = 1'b0;
      case (add_info)
         AI_ONE:   width = ARG_W1;
         AI_TWO:   width = ARG_W2;
         AI_FOUR:  width = ARG_W4;
         AI_EIGHT: width = ARG_W8;
         default: begin
            width    = ARG_W0;
            reserved = 1'b1;
         end
      endcase
   end

   // decode step
   always_comb begin
      nxt_state       = cur_state;
      result.valid    = 1'b0;
      result.argument = 64'd0;
      result.status   = STATUS_OK;

      if (cur_state.error_latched) begin
         // drop bytes until the buffer ends
         if (buffer_end) begin
            nxt_state = IDLE_STATE;
         end
      end else if (cur_state.bytes_left == ARG_W0) begin
         // initial byte
         if (major != head_major || (add_info >= AI_ONE && reserved)) begin
            nxt_state               = IDLE_STATE;
            nxt_state.error_latched = !buffer_end;
            result.valid            = 1'b1;
            result.status           = STATUS_ERR;
         end else if (add_info < AI_ONE) begin
            nxt_state       = IDLE_STATE;
            result.valid    = 1'b1;
            result.argument = {59'd0, add_info};
         end else if (buffer_end) begin
            // truncated head
            nxt_state     = IDLE_STATE;
            result.valid  = 1'b1;
            result.status = STATUS_ERR;
         end else begin
            nxt_state.bytes_left  = width;
            nxt_state.arg_width   = width;
            nxt_state.accumulator = 64'd0;
         end
      end else if (left_m1 != ARG_W0) begin
         // argument byte with more to come
         if (buffer_end) begin
            nxt_state     = IDLE_STATE;
            result.valid  = 1'b1;
            result.status = STATUS_ERR;
         end else begin
            nxt_state.bytes_left  = left_m1;
            nxt_state.accumulator = acc_shift;
         end
      end else begin
         // last argument byte
         nxt_state    = IDLE_STATE;
         result.valid = 1'b1;
         if (!is_minimal(cur_state.arg_width, acc_shift)) begin
            nxt_state.error_latched = !buffer_end;
            result.status           = STATUS_ERR;
         end else begin
            result.argument = acc_shift;
         end
      end
   end

endmodule

// ===== sv/cbor_canonical_head_decoder_core.sv =====
// cbor data item head decoder, one byte per request
// output: a registered result appears on rsp_ch in the cycle after the request that finishes a head
// throughput: one byte per cycle; a request is held off only while a result waits in
// the output register and the result side is not ready in that cycle
// reset (synchronous, active high) returns to awaiting an initial byte, no result pending
module cbor_canonical_head_decoder_core (
   input logic        clock,
   input logic        reset,
   cchd_req_if.sink   req_ch,
   cchd_rsp_if.source rsp_ch
);
   import cchd_pkg::*;

   head_state_type  state_ff;
   head_state_type  state_in;
   head_result_type step_result;
   logic            rsp_valid_ff;
   logic [63:0]     rsp_argument_ff;
   logic            rsp_status_ff;
   logic            req_fire;

   // accept a request whenever the output register is free or being drained
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   cchd_head_step u_step (
      .cur_state      (state_ff),
      .data_byte      (req_ch.data_byte),
      .head_major     (req_ch.head_major),
      .buffer_end     (req_ch.buffer_end),
      .nxt_state      (state_in),
      .result         (step_result)
   );

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_STATE;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= step_result.valid;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (req_fire && step_result.valid) begin
         rsp_argument_ff <= step_result.argument;
         rsp_status_ff   <= step_result.status;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.argument = rsp_argument_ff;
   assign rsp_ch.status   = rsp_status_ff;

endmodule
